>>> rtl/assert_macros.svh
// Assertion macros shared by the looper RTL; they vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a condition at every clock edge outside reset.
`define ALRP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Checks that a trigger is followed by a consequence in the next cycle.
`define ALRP_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
        else $error(msg);
`else
`define ALRP_ASSERT(lbl, clk, rst_n, prop, msg)
`define ALRP_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg)
`endif
`endif

>>> rtl/alrp_pkg.sv
// Types, constants and codes shared by the audio looper modules.
package alrp_pkg;

    // Fixed field widths of the beats and the configuration port.
    localparam int SAMPLE_BITS   = 16;
    localparam int CH_BITS       = 2;
    localparam int FRAME_BITS    = 15;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 15;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_FRAMES   = 16384;
    localparam int DEF_MAX_CHANNELS = 2;

    // Register reset values.
    localparam logic [CH_BITS-1:0]    CC_RESET = 2'd2;
    localparam logic [FRAME_BITS-1:0] FL_RESET = 15'd16384;

    // Saturation rails.
    localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_COUNT = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_LIMIT   = 1'd1;

    // Item function codes.
    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_STOP   = 2'd1,
        FUNC_RECORD = 2'd2,
        FUNC_PLAY   = 2'd3
    } t_func;

    // Input beat.
    typedef struct packed {
        t_func                         func;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic signed [SAMPLE_BITS-1:0] mix_in;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mix_out;
        logic                          clipped;
        logic                          is_recording;
        logic [FRAME_BITS-1:0]         loop_frames;
    } t_out_beat;

    // Item data carried past the memory read into the mix stage.
    typedef struct packed {
        logic                          play;
        logic signed [SAMPLE_BITS-1:0] mix_in;
        logic                          is_recording;
        logic [FRAME_BITS-1:0]         loop_frames;
    } t_alrp_meta;

endpackage

>>> rtl/audio_loop_record_playback.sv
// Top level of the audio looper: control state, loop memory and handshakes.
//
// Usage: one interleaved sample per input beat on i_valid/o_stall with payload
// i_data (func, sample_in, mix_in). Every accepted beat yields exactly one
// result beat on o_valid/i_stall with payload o_data (mix_out, clipped,
// is_recording, loop_frames), in order.
// A beat waits in the mix stage during its memory read, then in the output
// register that drives o_valid. Throughput is one beat per cycle unless the
// receiver stalls: the memory is accessed at most once per item, a record beat
// writes it and a playback beat reads it; the sum is formed in the next cycle.
// Results are buffered by a mix stage and an output register, so new beats
// are accepted while a finished result waits; when the receiver stalls, both
// fill and o_stall rises until a result is taken.
// A playback beat takes its position modulo the current loop size as it is
// accepted, so a channel_count write never stalls the input.
// Configuration (i_cfg_we, i_cfg_idx, i_cfg_wdata) is to be written while idle
// by the user; the block does not enforce it. Reset clears positions, loop
// length, recording flag and both pipeline stages and restores the registers;
// the loop memory is not cleared and no loop exists until one is recorded.
`include "assert_macros.svh"

module audio_loop_record_playback #(
    parameter int MAX_FRAMES   = alrp_pkg::DEF_MAX_FRAMES,
    parameter int MAX_CHANNELS = alrp_pkg::DEF_MAX_CHANNELS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  alrp_pkg::t_in_beat                    i_data,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output alrp_pkg::t_out_beat                   o_data,
    input  logic                                  i_cfg_we,
    input  logic [alrp_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [alrp_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata
);
    import alrp_pkg::*;

    localparam int DEPTH   = MAX_FRAMES * MAX_CHANNELS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int POS_W   = $clog2(DEPTH + 1);
    localparam int LEN_W   = $clog2(MAX_FRAMES + 1);
    localparam int TOT_W   = LEN_W + CH_BITS;
    localparam int CAP_W   = FRAME_BITS + CH_BITS;
    localparam int CMP_A   = (POS_W > CAP_W) ? POS_W : CAP_W;
    localparam int CMP_W   = ((CMP_A > TOT_W) ? CMP_A : TOT_W) + 1;
    localparam int PROD_W  = 2 * POS_W + 3;
    localparam longint DIV3_M = ((longint'(1) << (POS_W + 2)) + 2) / 3;

    // Configuration registers.
    logic [CH_BITS-1:0]    r_chan_cnt;
    logic [FRAME_BITS-1:0] r_frame_lim;

    // Control state.
    logic                  r_rec_flag,  n_rec_flag;
    logic [POS_W-1:0]      r_rec_pos,   n_rec_pos;
    logic [ADDR_W-1:0]     r_play_pos,  n_play_pos;
    logic [LEN_W-1:0]      r_loop_len,  n_loop_len;

    // Loop memory and its registered read port.
    logic signed [SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rd_data;

    logic [CH_BITS-1:0]    w_eff_ch;
    logic [FRAME_BITS-1:0] w_eff_fr;
    logic [TOT_W-1:0]      w_total;
    logic [CAP_W-1:0]      w_cap;
    logic [CMP_W-1:0]      w_rec_inc;
    logic [CMP_W-1:0]      w_pos_mod;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic [CMP_W-1:0]      w_play_inc;
    logic [PROD_W-1:0]     w_div3_prod;
    logic [POS_W-1:0]      w_rec_frames;
    logic [LEN_W-1:0]      w_stop_len;
    logic                  w_stage_ready;
    logic                  w_accept;
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic                  w_play_act;
    t_alrp_meta            w_meta;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt  <= CC_RESET;
            r_frame_lim <= FL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANNEL_COUNT: r_chan_cnt  <= i_cfg_wdata[CH_BITS-1:0];
                CFG_FRAME_LIMIT:   r_frame_lim <= i_cfg_wdata[FRAME_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective register values after clamping into range.
    always_comb begin
        if (r_chan_cnt == '0) begin
            w_eff_ch = CH_BITS'(1);
        end else if (r_chan_cnt > MAX_CHANNELS) begin
            w_eff_ch = CH_BITS'(MAX_CHANNELS);
        end else begin
            w_eff_ch = r_chan_cnt;
        end
        if (r_frame_lim == '0) begin
            w_eff_fr = FRAME_BITS'(1);
        end else if (r_frame_lim > MAX_FRAMES) begin
            w_eff_fr = FRAME_BITS'(MAX_FRAMES);
        end else begin
            w_eff_fr = r_frame_lim;
        end
    end

    // Loop size and recording capacity in samples.
    assign w_total    = TOT_W'(r_loop_len) * TOT_W'(w_eff_ch);
    assign w_cap      = CAP_W'(w_eff_fr) * CAP_W'(w_eff_ch);
    assign w_rec_inc  = CMP_W'(r_rec_pos) + CMP_W'(1);

    // The stored position is below three loop sizes, since it was set under a
    // channel count of at most three for the same loop length; two compare and
    // subtract steps bring it below the current loop size.
    always_comb begin
        w_pos_mod = CMP_W'(r_play_pos);
        if (w_pos_mod >= CMP_W'(w_total)) begin
            w_pos_mod = w_pos_mod - CMP_W'(w_total);
        end
        if (w_pos_mod >= CMP_W'(w_total)) begin
            w_pos_mod = w_pos_mod - CMP_W'(w_total);
        end
    end
    assign w_rd_addr  = ADDR_W'(w_pos_mod);
    assign w_play_inc = w_pos_mod + CMP_W'(1);

    // Whole frames recorded so far, for a stop; division by 3 uses a reciprocal.
    assign w_div3_prod = PROD_W'(r_rec_pos) * PROD_W'(DIV3_M);
    always_comb begin
        case (w_eff_ch)
            2'd2:    w_rec_frames = r_rec_pos >> 1;
            2'd3:    w_rec_frames = POS_W'(w_div3_prod >> (POS_W + 2));
            default: w_rec_frames = r_rec_pos;
        endcase
        if (CMP_W'(w_rec_frames) > CMP_W'(w_eff_fr)) begin
            w_stop_len = LEN_W'(w_eff_fr);
        end else begin
            w_stop_len = LEN_W'(w_rec_frames);
        end
    end

    // The input waits only for room in the result pipeline.
    assign o_stall        = !w_stage_ready;
    assign w_accept       = i_valid && !o_stall;

    // Next control state and memory access for the accepted beat.
    always_comb begin
        n_rec_flag = r_rec_flag;
        n_rec_pos  = r_rec_pos;
        n_play_pos = r_play_pos;
        n_loop_len = r_loop_len;
        w_wr_en    = 1'b0;
        w_rd_en    = 1'b0;
        w_play_act = 1'b0;
        if (w_accept) begin
            case (i_data.func)
                FUNC_START: begin
                    n_rec_flag = 1'b1;
                end
                FUNC_STOP: begin
                    if (r_rec_flag) begin
                        n_loop_len = w_stop_len;
                        n_rec_pos  = '0;
                        n_play_pos = '0;
                        n_rec_flag = 1'b0;
                    end
                end
                FUNC_RECORD: begin
                    if (r_rec_flag) begin
                        if (CMP_W'(r_rec_pos) < CMP_W'(w_cap)) begin
                            w_wr_en   = 1'b1;
                            n_rec_pos = POS_W'(w_rec_inc);
                        end
                        // Filling the capacity ends the take at the frame limit.
                        if (w_rec_inc >= CMP_W'(w_cap)) begin
                            n_loop_len = LEN_W'(w_eff_fr);
                            n_rec_pos  = '0;
                            n_play_pos = '0;
                            n_rec_flag = 1'b0;
                        end
                    end
                end
                FUNC_PLAY: begin
                    if (r_loop_len != '0 && !r_rec_flag) begin
                        w_rd_en    = 1'b1;
                        w_play_act = 1'b1;
                        if (w_play_inc >= CMP_W'(w_total)) begin
                            n_play_pos = '0;
                        end else begin
                            n_play_pos = ADDR_W'(w_play_inc);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_flag <= 1'b0;
            r_rec_pos  <= '0;
            r_play_pos <= '0;
            r_loop_len <= '0;
        end else begin
            r_rec_flag <= n_rec_flag;
            r_rec_pos  <= n_rec_pos;
            r_play_pos <= n_play_pos;
            r_loop_len <= n_loop_len;
        end
    end

    // Loop memory: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_rec_pos[ADDR_W-1:0]] <= i_data.sample_in;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Item data for the mix stage.
    always_comb begin
        w_meta.play         = w_play_act;
        w_meta.mix_in       = i_data.mix_in;
        w_meta.is_recording = n_rec_flag;
        w_meta.loop_frames  = FRAME_BITS'(n_loop_len);
    end

    alrp_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_accept),
        .i_meta    (w_meta),
        .i_rd_data (r_rd_data),
        .i_stall   (i_stall),
        .o_ready   (w_stage_ready),
        .o_valid   (o_valid),
        .o_data    (o_data)
    );

    `ALRP_ASSERT(a_len_bound, i_clk, i_rst_n, r_loop_len <= MAX_FRAMES, "loop length beyond the memory")
    `ALRP_ASSERT(a_play_in_loop, i_clk, i_rst_n, !w_rd_en || w_pos_mod < CMP_W'(w_total), "playback address beyond the loop")
    `ALRP_ASSERT_NEXT(a_stop_clears, i_clk, i_rst_n, w_accept && i_data.func == FUNC_STOP && r_rec_flag, !r_rec_flag && r_rec_pos == '0 && r_play_pos == '0, "stop did not end the recording")

endmodule

>>> rtl/alrp_out_stage.sv
// Mix stage and output register of the looper: saturating add and result handshake.
`include "assert_macros.svh"

module alrp_out_stage (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  alrp_pkg::t_alrp_meta                  i_meta,
    input  logic signed [alrp_pkg::SAMPLE_BITS-1:0] i_rd_data,
    input  logic                                  i_stall,
    output logic                                  o_ready,
    output logic                                  o_valid,
    output alrp_pkg::t_out_beat                   o_data
);
    import alrp_pkg::*;

    logic                          r_s1_valid;
    t_alrp_meta                    r_s1_meta;
    logic                          r_out_valid;
    t_out_beat                     r_out;
    logic                          w_out_free;
    logic                          w_s1_move;
    logic signed [SAMPLE_BITS:0]   w_sum;
    t_out_beat                     w_result;

    // The output register frees up when empty or when its beat is taken.
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_ready    = !r_s1_valid || w_out_free;

    // Saturating mix of the stored sample into mix_in.
    always_comb begin
        w_sum = {r_s1_meta.mix_in[SAMPLE_BITS-1], r_s1_meta.mix_in}
              + {i_rd_data[SAMPLE_BITS-1], i_rd_data};
        w_result.is_recording = r_s1_meta.is_recording;
        w_result.loop_frames  = r_s1_meta.loop_frames;
        w_result.mix_out      = r_s1_meta.mix_in;
        w_result.clipped      = 1'b0;
        if (r_s1_meta.play) begin
            if (w_sum[SAMPLE_BITS] != w_sum[SAMPLE_BITS-1]) begin
                w_result.mix_out = w_sum[SAMPLE_BITS] ? SAT_LO : SAT_HI;
                w_result.clipped = 1'b1;
            end else begin
                w_result.mix_out = w_sum[SAMPLE_BITS-1:0];
            end
        end
    end

    // Stage one holds the item while the memory read completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_load) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
        if (i_load) begin
            r_s1_meta <= i_meta;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
        if (w_s1_move) begin
            r_out <= w_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `ALRP_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !w_out_free, r_s1_valid && $stable(r_s1_meta), "stage one lost or changed a blocked beat")
    `ALRP_ASSERT(a_clip_rail, i_clk, i_rst_n, !(r_out_valid && r_out.clipped) || r_out.mix_out == SAT_HI || r_out.mix_out == SAT_LO, "clipped result is not at a rail")
    `ALRP_ASSERT(a_pass_noclip, i_clk, i_rst_n, !(r_s1_valid && !r_s1_meta.play) || (!w_result.clipped && w_result.mix_out == r_s1_meta.mix_in), "passthrough beat altered")

endmodule
